>>> hdl/oqkr_pkg.sv
// shared types and constants for the ordered queue with keyed removal
`timescale 1ns / 1ps
`default_nettype none
package oqkr_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int KEY_WIDTH_DEF = 16;

    localparam int CMD_W         = 2;
    localparam int KEY_FIELD_W   = 16;
    localparam int STATUS_W      = 2;
    localparam int COUNT_FIELD_W = 5;

    localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic             sample;
        logic             apply;
        logic [CMD_W-1:0] op;
    } t_cell_ctl;

endpackage
`default_nettype wire

>>> hdl/oqkr_if.sv
// valid/ready channel interfaces for command items and result items
`timescale 1ns / 1ps
`default_nettype none
interface oqkr_in_if
    import oqkr_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [CMD_W-1:0]       command;
    logic [KEY_FIELD_W-1:0] key;

    modport source (output valid, output command, output key, input ready);
    modport sink   (input valid, input command, input key, output ready);
endinterface

interface oqkr_out_if
    import oqkr_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic [KEY_FIELD_W-1:0]   popped_key;
    logic [COUNT_FIELD_W-1:0] entry_count;

    modport source (output valid, output status, output popped_key, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input popped_key, input entry_count,
                    output ready);
endinterface
`default_nettype wire

>>> hdl/oqkr_cell.sv
// one queue slot: holds a key, matches it and shifts from its upper neighbor
`timescale 1ns / 1ps
`default_nettype none
module oqkr_cell
    import oqkr_pkg::*;
#(
    parameter int KEY_WIDTH = KEY_WIDTH_DEF,
    parameter bit IS_HEAD   = 1'b0
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cell_ctl            i_ctl,
    input  wire logic [KEY_WIDTH-1:0] i_key,
    input  wire logic                 i_shift,
    input  wire logic                 i_prev_valid,
    input  wire logic                 i_next_valid,
    input  wire logic [KEY_WIDTH-1:0] i_next_key,
    output logic                      o_valid,
    output logic [KEY_WIDTH-1:0]      o_key,
    output logic                      o_hit
);

    logic                 r_valid;
    logic                 r_hit;
    logic [KEY_WIDTH-1:0] r_key;
    logic                 w_push_here;

    assign w_push_here = (i_ctl.op == CMD_PUSH) && !r_valid && i_prev_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hit   <= 1'b0;
        end else if (i_ctl.sample) begin
            unique case (i_ctl.op)
                CMD_DELETE: r_hit <= r_valid && (r_key == i_key);
                CMD_POP:    r_hit <= r_valid && IS_HEAD;
                default:    r_hit <= 1'b0;
            endcase
        end else if (i_ctl.apply) begin
            r_hit <= 1'b0;
            if (i_shift) begin
                r_valid <= i_next_valid;
            end else if (w_push_here) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.apply && !i_ctl.sample) begin
            if (i_shift) begin
                r_key <= i_next_key;
            end else if (w_push_here) begin
                r_key <= i_key;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_key   = r_key;
    assign o_hit   = r_hit;

endmodule
`default_nettype wire

>>> hdl/ordered_queue_with_keyed_removal_unit.sv
// top level: ordered key queue with push, pop and delete by key
// an accepted item enters the execute state; its result is registered once the output is free
// one item at a time: on acceptance each cell records a hit (key match on delete, head on pop);
// then the first-match prefix shifts cells to close the gap, or a push fills the first free cell
// reset: entry count cleared and all cells marked empty; stored keys are not cleared
`timescale 1ns / 1ps
`default_nettype none
module ordered_queue_with_keyed_removal_unit
    import oqkr_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    oqkr_in_if.sink    i_in,
    oqkr_out_if.source o_out
);

    localparam int CW  = $clog2(DEPTH + 1);
    localparam int LVL = $clog2(DEPTH);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state                  r_state;
    logic [CMD_W-1:0]        r_op;
    logic [KEY_WIDTH-1:0]    r_op_key;
    logic [CW-1:0]           r_cnt;
    logic                    r_out_valid;
    logic [STATUS_W-1:0]     r_status;
    logic [KEY_FIELD_W-1:0]  r_popped;
    logic [COUNT_FIELD_W-1:0] r_count;

    t_cell_ctl               w_ctl;
    logic                    w_accept;
    logic                    w_out_free;
    logic [KEY_WIDTH-1:0]    w_bkey;
    logic [KEY_WIDTH-1:0]    w_key [DEPTH];
    logic [DEPTH-1:0]        w_valid;
    logic [DEPTH-1:0]        w_hit;
    logic [DEPTH-1:0]        w_pre [LVL+1];
    logic                    w_full;
    logic                    w_empty;
    logic                    w_found;
    logic [CW-1:0]           n_cnt;
    logic [STATUS_W-1:0]     n_status;
    logic [KEY_FIELD_W-1:0]  n_popped;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;

    assign w_ctl.sample = w_accept;
    assign w_ctl.apply  = (r_state == S_EXEC) && w_out_free;
    assign w_ctl.op     = w_accept ? i_in.command : r_op;
    assign w_bkey       = w_accept ? KEY_WIDTH'(i_in.key) : r_op_key;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic                 w_prev_valid;
            logic                 w_next_valid;
            logic [KEY_WIDTH-1:0] w_next_key;
            if (g == 0) begin : g_head
                assign w_prev_valid = 1'b1;
            end else begin : g_body
                assign w_prev_valid = w_valid[g-1];
            end
            if (g == DEPTH - 1) begin : g_tail
                assign w_next_valid = 1'b0;
                assign w_next_key   = '0;
            end else begin : g_inner
                assign w_next_valid = w_valid[g+1];
                assign w_next_key   = w_key[g+1];
            end
            oqkr_cell #(
                .KEY_WIDTH (KEY_WIDTH),
                .IS_HEAD   (g == 0)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_key        (w_bkey),
                .i_shift      (w_pre[LVL][g]),
                .i_prev_valid (w_prev_valid),
                .i_next_valid (w_next_valid),
                .i_next_key   (w_next_key),
                .o_valid      (w_valid[g]),
                .o_key        (w_key[g]),
                .o_hit        (w_hit[g])
            );
        end
    endgenerate

    // first-match prefix over the hit bits
    always_comb begin
        w_pre[0] = w_hit;
        for (int lv = 0; lv < LVL; lv++) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (i >= (1 << lv)) begin
                    w_pre[lv+1][i] = w_pre[lv][i] | w_pre[lv][i - (1 << lv)];
                end else begin
                    w_pre[lv+1][i] = w_pre[lv][i];
                end
            end
        end
    end

    assign w_full  = w_valid[DEPTH-1];
    assign w_empty = !w_valid[0];
    assign w_found = w_pre[LVL][DEPTH-1];

    always_comb begin
        n_cnt    = r_cnt;
        n_status = ST_OK;
        n_popped = '0;
        unique case (r_op)
            CMD_PUSH: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            CMD_POP: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_popped = KEY_FIELD_W'(w_key[0]);
                    n_cnt    = r_cnt - CW'(1);
                end
            end
            CMD_DELETE: begin
                if (w_found) begin
                    n_cnt = r_cnt - CW'(1);
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_EXEC && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op     <= i_in.command;
                        r_op_key <= KEY_WIDTH'(i_in.key);
                        r_state  <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_out_free) begin
                        r_cnt       <= n_cnt;
                        r_status    <= n_status;
                        r_popped    <= n_popped;
                        r_count     <= COUNT_FIELD_W'(n_cnt);
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_status;
    assign o_out.popped_key  = r_popped;
    assign o_out.entry_count = r_count;

    a_cnt_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == CW'($countones(w_valid)))
        else $error("entry count differs from occupied cells");

    a_cells_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid + DEPTH'(1))) == '0)
        else $error("occupied cells are not packed toward the head");

    a_result_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EXEC))
        else $error("result appeared without an executed item");

    a_hits_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !w_accept) |=> (w_hit == '0 || $past(r_state) == S_EXEC))
        else $error("stale match bits left in cells");

endmodule
`default_nettype wire
